// File: design/tccw_pkg.sv
// shared types and constants for the text console cell writer
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int CELL_ADDR_W = 11;
    localparam int CELL_W      = 16;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd23;

    typedef struct packed {
        logic [1:0]             op;
        logic [7:0]             char_code;
        logic [CELL_ADDR_W-1:0] cell_address;
    } request_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
    } result_t;

    typedef struct packed {
        logic capture;
        logic init_step;
        logic clear_step;
        logic clear_done;
        logic scroll_step;
        logic scroll_home;
        logic put_char;
        logic use_latch;
        logic newline;
        logic read_issue;
        logic read_emit;
        logic plain_emit;
    } cmd_t;

    typedef struct packed {
        logic row_full;
        logic is_newline;
        logic last_all;
        logic last_scroll;
    } status_t;

endpackage

// File: design/tccw_ctrl.sv
// controller state machine for the text console cell writer
`timescale 1ns / 1ps

module tccw_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       op,
    input  tccw_pkg::status_t status,
    output tccw_pkg::cmd_t   cmd,
    output logic             busy
);

    typedef enum logic [6:0] {
        ST_INIT       = 7'b0000001,
        ST_IDLE       = 7'b0000010,
        ST_READ       = 7'b0000100,
        ST_CLEAR      = 7'b0001000,
        ST_SCROLL     = 7'b0010000,
        ST_SCROLL_END = 7'b0100000,
        ST_PUT        = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.last_all)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    priority if (op == tccw_pkg::OP_PUT)
                    begin
                        priority if (status.is_newline)
                        begin
                            cmd.newline = 1'b1;
                        end
                        else if (status.row_full)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            cmd.put_char = 1'b1;
                        end
                    end
                    else if (op == tccw_pkg::OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (op == tccw_pkg::OP_READ)
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_READ;
                    end
                    else
                    begin
                        cmd.plain_emit = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read_emit = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.last_all)
                begin
                    cmd.clear_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (status.last_scroll)
                begin
                    state_next = ST_SCROLL_END;
                end
            end
            ST_SCROLL_END:
            begin
                cmd.scroll_home = 1'b1;
                state_next      = ST_PUT;
            end
            ST_PUT:
            begin
                cmd.put_char  = 1'b1;
                cmd.use_latch = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: design/tccw_datapath.sv
// cell store, cursor, attribute and result registers for the text console cell writer
`timescale 1ns / 1ps

module tccw_datapath
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tccw_pkg::request_t request,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  tccw_pkg::cmd_t    cmd,
    output tccw_pkg::status_t status,
    output logic              done,
    output tccw_pkg::result_t result
);

    localparam int CELL_COUNT   = COLS * ROWS;
    localparam int SCROLL_COUNT = COLS * (ROWS - 1);
    localparam int ADDR_W       = $clog2(CELL_COUNT);
    localparam int ROW_W        = $clog2(ROWS + 1);
    localparam int COL_W        = $clog2(COLS);

    logic [tccw_pkg::CELL_W-1:0] mem [CELL_COUNT];

    logic [ROW_W-1:0]            row_reg;
    logic [ROW_W-1:0]            row_next;
    logic [COL_W-1:0]            col_reg;
    logic [COL_W-1:0]            col_next;
    logic [ADDR_W-1:0]           count_reg;
    logic [ADDR_W-1:0]           count_next;
    logic [7:0]                  attr_reg;
    logic [7:0]                  char_reg;
    logic                        range_reg;
    logic                        pend_reg;
    logic [ADDR_W-1:0]           pend_addr_reg;
    logic [tccw_pkg::CELL_W-1:0] rd_data_reg;
    logic                        done_reg;
    logic                        done_next;
    tccw_pkg::result_t           result_reg;
    tccw_pkg::result_t           result_next;

    logic                        in_range;
    logic [ADDR_W-1:0]           cur_idx;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        we;
    logic [ADDR_W-1:0]           wa;
    logic [tccw_pkg::CELL_W-1:0] wd;
    logic [7:0]                  put_code;

    assign in_range = (32'(request.cell_address) < 32'(CELL_COUNT));
    assign cur_idx  = ADDR_W'(32'(row_reg) * COLS + 32'(col_reg));
    assign put_code = cmd.use_latch ? char_reg : request.char_code;

    assign status.row_full    = (row_reg == ROW_W'(ROWS));
    assign status.is_newline  = (request.char_code == tccw_pkg::NEWLINE_CODE);
    assign status.last_all    = (count_reg == ADDR_W'(CELL_COUNT - 1));
    assign status.last_scroll = (count_reg == ADDR_W'(SCROLL_COUNT - 1));

    always_comb
    begin
        if (cmd.scroll_step)
        begin
            rd_addr = count_reg + ADDR_W'(COLS);
        end
        else if (cmd.read_issue && in_range)
        begin
            rd_addr = ADDR_W'(request.cell_address);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        priority if (pend_reg)
        begin
            we = 1'b1;
            wa = pend_addr_reg;
            wd = rd_data_reg;
        end
        else if (cmd.init_step)
        begin
            we = 1'b1;
            wa = count_reg;
            wd = {tccw_pkg::ATTR_RESET, tccw_pkg::SPACE_CODE};
        end
        else if (cmd.clear_step)
        begin
            we = 1'b1;
            wa = count_reg;
            wd = {attr_reg, tccw_pkg::SPACE_CODE};
        end
        else if (cmd.put_char)
        begin
            we = 1'b1;
            wa = cur_idx;
            wd = {attr_reg, put_code};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.init_step || cmd.clear_step)
        begin
            count_next = status.last_all ? '0 : count_reg + 1'b1;
        end
        else if (cmd.scroll_step)
        begin
            count_next = status.last_scroll ? '0 : count_reg + 1'b1;
        end
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        priority if (cmd.newline)
        begin
            col_next = '0;
            if (!status.row_full)
            begin
                row_next = row_reg + 1'b1;
            end
        end
        else if (cmd.put_char)
        begin
            if (col_reg == COL_W'(COLS - 1))
            begin
                col_next = '0;
                row_next = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        else if (cmd.scroll_home)
        begin
            row_next = ROW_W'(ROWS - 1);
            col_next = '0;
        end
        else if (cmd.clear_done)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_comb
    begin
        done_next              = cmd.newline | cmd.put_char | cmd.read_emit
                               | cmd.plain_emit | cmd.clear_done;
        result_next.cell_data  = (cmd.read_emit && range_reg) ? rd_data_reg : '0;
        result_next.cursor_row = tccw_pkg::ROW_OUT_W'(row_next);
        result_next.cursor_col = tccw_pkg::COL_OUT_W'(col_next);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= count_reg;
        result_reg    <= result_next;
        if (cmd.capture)
        begin
            char_reg  <= request.char_code;
            range_reg <= in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            count_reg <= '0;
            attr_reg  <= tccw_pkg::ATTR_RESET;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            count_reg <= count_next;
            pend_reg  <= cmd.scroll_step;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: design/text_console_cell_writer.sv
// top level of the text console cell writer
`timescale 1ns / 1ps

// character-cell text console over a COLS x ROWS store of 16-bit cells
// (character byte low, attribute byte high)
// a request word is taken when start is high and busy is low
// every request gives one result word, shown for one cycle with done high
// put of a newline, put without scroll and unused op: result the cycle after start
// read: the store read is registered, and the result is registered after it
// clear: writes each cell, one cell a cycle, result the cycle after the last write
// put that scrolls: moves each row up one through the one read and one
// write port, then a home and a put state, result the cycle after the put
// busy is low while a result is shown, so the next request may go in then
// cfg_we writes the attribute for new cells at any idle cycle
// after reset the block walks every cell of the store to fill it with
// blanks in the reset attribute, busy high all the while
// the receiver cannot stall: done is a one-cycle strobe
module text_console_cell_writer
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tccw_pkg::request_t request,
    output logic              done,
    output tccw_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data
);

    tccw_pkg::cmd_t    cmd;
    tccw_pkg::status_t status;

    tccw_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (request.op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tccw_datapath
    #(
        .COLS (COLS),
        .ROWS (ROWS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .done     (done),
        .result   (result)
    );

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the text console cell writer
`timescale 1ns / 1ps

module tb_top;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLS * ROWS;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WORDS_PER_PHASE = 135;

    class console_board;
        logic [15:0] cells [CELL_COUNT];
        int unsigned row_pos;
        int unsigned col_pos;
        logic [7:0]  attribute;
        tccw_pkg::result_t awaited [$];
        int          errors;

        function new();
            attribute = tccw_pkg::ATTR_RESET;
            row_pos   = 0;
            col_pos   = 0;
            errors    = 0;
            blank_screen();
        endfunction

        function void blank_screen();
            foreach (cells[i])
                cells[i] = {attribute, tccw_pkg::SPACE_CODE};
        endfunction

        function void scroll_up();
            for (int i = 0; i < CELL_COUNT - COLS; i++)
                cells[i] = cells[i + COLS];
            row_pos = ROWS - 1;
            col_pos = 0;
        endfunction

        function void put_char(logic [7:0] ch);
            int unsigned idx;
            if (ch == tccw_pkg::NEWLINE_CODE)
            begin
                if (row_pos < ROWS)
                    row_pos++;
                col_pos = 0;
                return;
            end
            if (row_pos >= ROWS)
                scroll_up();
            idx = row_pos * COLS + col_pos;
            if (idx < CELL_COUNT)
                cells[idx] = {attribute, ch};
            col_pos++;
            if (col_pos >= COLS)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= ROWS)
                    row_pos = 0;
            end
        endfunction

        // apply one accepted word and queue the result it must give
        function void note_request(tccw_pkg::request_t w);
            tccw_pkg::result_t want;
            want.cell_data = '0;
            case (w.op)
                tccw_pkg::OP_PUT:   put_char(w.char_code);
                tccw_pkg::OP_CLEAR:
                begin
                    blank_screen();
                    row_pos = 0;
                    col_pos = 0;
                end
                tccw_pkg::OP_READ:
                begin
                    if (w.cell_address < CELL_COUNT)
                        want.cell_data = cells[w.cell_address];
                end
                default: ;
            endcase
            want.cursor_row = row_pos[tccw_pkg::ROW_OUT_W-1:0];
            want.cursor_col = col_pos[tccw_pkg::COL_OUT_W-1:0];
            awaited.push_back(want);
        endfunction

        function void report_miss(string what, tccw_pkg::result_t want,
                                  tccw_pkg::result_t got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected data %h row %0d col %0d, %s %h row %0d col %0d",
                         $realtime, what, want.cell_data, want.cursor_row, want.cursor_col,
                         "got data", got.cell_data, got.cursor_row, got.cursor_col);
        endfunction

        function void check_result(tccw_pkg::result_t got);
            tccw_pkg::result_t want;
            if (awaited.size() == 0)
            begin
                want = '0;
                report_miss("unexpected result", want, got);
                return;
            end
            want = awaited.pop_front();
            if (got.cell_data !== want.cell_data || got.cursor_row !== want.cursor_row
                || got.cursor_col !== want.cursor_col)
                report_miss("mismatch", want, got);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function int cursor_cell();
            return int'(row_pos * COLS + col_pos);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    tccw_pkg::request_t request;
    logic               done;
    tccw_pkg::result_t  result;
    logic               cfg_we;
    logic [7:0]         cfg_data;

    console_board board;
    int         words_sent;
    bit         no_gaps;

    text_console_cell_writer uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(result);
            if (start && !busy)
                board.note_request(request);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (ch == tccw_pkg::NEWLINE_CODE)
            ch = tccw_pkg::SPACE_CODE;
        return ch;
    endfunction

    task automatic send_word(logic [1:0] op, logic [7:0] ch, logic [10:0] addr);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start                = 1'b1;
        request.op           = op;
        request.char_code    = ch;
        request.cell_address = addr;
        do
            @(posedge clk);
        while (busy);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // hold off until every awaited result is back and the block is idle
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (board.outstanding() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_attribute(logic [7:0] value);
        drain();
        cfg_data = value;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        board.attribute = value;
    endtask

    task automatic random_sequence();
        int kind;
        int n;
        int base;
        int off;
        kind    = $urandom_range(0, 99);
        no_gaps = ($urandom_range(0, 3) == 0);
        if (kind < 35)
        begin
            n = $urandom_range(1, 20);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE,
                              11'($urandom_range(0, 2047)));
                else
                    send_word(tccw_pkg::OP_PUT, 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, 2047)));
            end
        end
        else if (kind < 50)
        begin
            // long line: wraps the column, and the row after a scroll
            n = $urandom_range(78, 84);
            repeat (n)
                send_word(tccw_pkg::OP_PUT, plain_char(), 11'($urandom_range(0, 2047)));
        end
        else if (kind < 62)
        begin
            n = $urandom_range(20, 30);
            repeat (n)
                send_word(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE,
                          11'($urandom_range(0, 2047)));
        end
        else if (kind < 85)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_word(tccw_pkg::OP_READ, 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, 2047)));
                end
                else
                begin
                    base = board.cursor_cell();
                    off  = $urandom_range(0, 3);
                    send_word(tccw_pkg::OP_READ, 8'($urandom_range(0, 255)),
                              (base >= off) ? 11'(base - off) : 11'(base));
                end
            end
        end
        else if (kind < 90)
        begin
            send_word(tccw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)));
        end
        else if (kind < 95)
        begin
            send_word(OP_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end
        else
        begin
            // a printable right after a full set of newlines forces a scroll
            repeat (ROWS + 1)
                send_word(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE,
                          11'($urandom_range(0, 2047)));
            send_word(tccw_pkg::OP_PUT, plain_char(), 11'($urandom_range(0, 2047)));
            send_word(tccw_pkg::OP_READ, 8'h00, 11'((ROWS - 1) * COLS));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int target;
        board      = new();
        words_sent = 0;
        no_gaps    = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_we     = 1'b0;
        cfg_data   = 8'h00;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // reset contents, read range edges, unused op, puts and read-back
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'hFF, 11'd1999);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd2000);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd2047);
        send_word(OP_UNUSED, 8'hFF, 11'h7FF);
        send_word(tccw_pkg::OP_PUT, 8'h00, 11'd0);
        send_word(tccw_pkg::OP_PUT, 8'hFF, 11'h7FF);
        send_word(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE, 11'd0);
        send_word(tccw_pkg::OP_PUT, 8'h41, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd1);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd80);

        // attribute extremes
        set_attribute(8'h00);
        send_word(tccw_pkg::OP_PUT, 8'h7E, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd81);
        send_word(tccw_pkg::OP_CLEAR, 8'h00, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd1024);
        set_attribute(8'hFF);
        send_word(tccw_pkg::OP_PUT, 8'h55, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd0);
        send_word(tccw_pkg::OP_CLEAR, 8'hFF, 11'h7FF);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd1999);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd1023);

        for (int p = 0; p < 4; p++)
        begin
            set_attribute(8'($urandom_range(0, 255)));
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target)
                random_sequence();
        end

        drain();
        repeat (20) @(negedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
design/tccw_pkg.sv
design/tccw_ctrl.sv
design/tccw_datapath.sv
design/text_console_cell_writer.sv
tb/sv/tb_top.sv
